>>> hdl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg: shared types and helpers of the base64 codec
// character mapping, character classes and the job record passed to the back end
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // character classes: 0..63 alphabet value
  localparam logic [6:0] CLS_PAD = 7'd64;
  localparam logic [6:0] CLS_BAD = 7'd65;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0]      bad;
    logic [2:0]      count;
    logic            last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r = 7'd62;
    end else if (c == 8'h2F) begin
      r = 7'd63;
    end else if (c == PAD_CHAR) begin
      r = CLS_PAD;
    end else begin
      r = CLS_BAD;
    end
    return r;
  endfunction

endpackage

>>> hdl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front: item intake and group tracking
// gathers encode and decode groups and turns each group into a job of results
// ----------------------------------------------------------------------------
module b64_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          in_ready,
  input  b64_pkg::q_stat_t q_stat,
  output logic          push,
  output b64_pkg::job_t push_job
);
  import b64_pkg::*;

  logic        direction;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [1:0]  pad_count, pad_count_next;

  logic        accept;
  job_t        job;

  // encode
  logic [23:0] enc_bits;
  logic [2:0]  enc_nchars;

  // decode
  logic [6:0]  cls;
  logic        is_pad, is_bad, rejected;
  logic [23:0] gb_after, fl_bits;
  logic [1:0]  gc_after, pad_after, data_n, fl_n;
  logic [7:0]  fl_b0, fl_b1;
  logic        fl_bad, do_flush;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (job.count != 3'd0);
  assign push_job = job;

  assign cls      = classify(in_byte);
  assign is_pad   = (cls == CLS_PAD);
  assign is_bad   = (cls == CLS_BAD);
  assign rejected = is_bad || (is_pad && group_count < 2'd2) ||
                    (!is_pad && pad_count != 2'd0);

  always_comb begin
    job              = '0;
    job.last         = in_last;
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_count_next   = pad_count;
    enc_bits         = '0;
    enc_nchars       = 3'd4;
    gb_after         = group_bits;
    gc_after         = group_count;
    pad_after        = pad_count;
    fl_bits          = '0;
    data_n           = '0;
    fl_n             = '0;
    fl_b0            = '0;
    fl_b1            = '0;
    fl_bad           = 1'b0;
    do_flush         = 1'b0;

    if (direction == DIR_ENCODE) begin
      if (group_count == 2'd2) begin
        enc_bits   = {group_bits[15:0], in_byte};
        enc_nchars = 3'd4;
        job.count  = 3'd4;
      end else if (in_last) begin
        enc_bits   = (group_count == 2'd0) ? {in_byte, 16'h0000}
                                           : {group_bits[7:0], in_byte, 8'h00};
        enc_nchars = {1'b0, group_count} + 3'd2;
        job.count  = 3'd4;
      end
      job.bytes[0] = enc_char(enc_bits[23:18]);
      job.bytes[1] = enc_char(enc_bits[17:12]);
      job.bytes[2] = (enc_nchars > 3'd2) ? enc_char(enc_bits[11:6]) : PAD_CHAR;
      job.bytes[3] = (enc_nchars > 3'd3) ? enc_char(enc_bits[5:0]) : PAD_CHAR;
      if (job.count != 3'd0) begin
        group_bits_next  = '0;
        group_count_next = '0;
      end else begin
        group_bits_next  = {group_bits[15:0], in_byte};
        group_count_next = group_count + 2'd1;
      end
      pad_count_next = '0;
    end else begin
      if (!rejected) begin
        gb_after  = {group_bits[17:0], is_pad ? 6'd0 : cls[5:0]};
        pad_after = pad_count + {1'b0, is_pad};
        if (group_count == 2'd3) begin
          gc_after = 2'd0;
        end else begin
          gc_after = group_count + 2'd1;
        end
      end

      do_flush = in_last && (gc_after != 2'd0);
      case (gc_after)
        2'd1:    fl_bits = {gb_after[5:0], 18'd0};
        2'd2:    fl_bits = {gb_after[11:0], 12'd0};
        2'd3:    fl_bits = {gb_after[17:0], 6'd0};
        default: fl_bits = '0;
      endcase
      data_n = gc_after - pad_after;
      if (data_n >= 2'd2) begin
        fl_n  = data_n - 2'd1;
        fl_b0 = fl_bits[23:16];
        fl_b1 = fl_bits[15:8];
      end else begin
        fl_n   = 2'd1;
        fl_bad = 1'b1;
      end

      if (rejected) begin
        job.bytes[0] = 8'h00;
        job.bad[0]   = 1'b1;
        job.count    = 3'd1;
        if (do_flush) begin
          job.bytes[1] = fl_b0;
          job.bytes[2] = fl_b1;
          job.bad[1]   = fl_bad;
          job.count    = 3'd1 + {1'b0, fl_n};
        end
      end else if (group_count == 2'd3) begin
        job.bytes[0] = gb_after[23:16];
        job.bytes[1] = gb_after[15:8];
        job.bytes[2] = gb_after[7:0];
        job.count    = 3'd3 - {1'b0, pad_after};
      end else if (do_flush) begin
        job.bytes[0] = fl_b0;
        job.bytes[1] = fl_b1;
        job.bad[0]   = fl_bad;
        job.count    = {1'b0, fl_n};
      end

      if (do_flush || (!rejected && group_count == 2'd3)) begin
        group_bits_next  = '0;
        group_count_next = '0;
        pad_count_next   = '0;
      end else begin
        group_bits_next  = gb_after;
        group_count_next = gc_after;
        pad_count_next   = pad_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= DIR_ENCODE;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
    end else if (cfg_wr_en) begin
      direction   <= cfg_wr_data;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_count   <= pad_count_next;
    end
  end

endmodule

>>> hdl/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue: job queue between front and back end
// small register queue so that intake and output stall independently
// ----------------------------------------------------------------------------
module b64_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64_pkg::job_t    push_job,
  input  logic             pop,
  output b64_pkg::job_t    pop_job,
  output b64_pkg::q_stat_t q_stat
);
  import b64_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign q_stat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign pop_job      = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill out of range");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1))
    else $error("queue fill not advanced on push");
`endif

endmodule

>>> hdl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back: result sequencer
// takes jobs from the queue and, while out_ready holds, sends their results one item per cycle
// ----------------------------------------------------------------------------
module b64_back (
  input  logic             clk,
  input  logic             rst,
  input  b64_pkg::q_stat_t q_stat,
  output logic             pop,
  input  b64_pkg::job_t    pop_job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_bad
);
  import b64_pkg::*;

  logic       busy;
  job_t       cur;
  logic [1:0] idx;
  logic       fin, adv;

  assign fin = busy && ({1'b0, idx} == cur.count - 3'd1);
  assign adv = !busy || (out_ready && fin);
  assign pop = adv && !q_stat.empty;

  assign out_valid = busy;
  assign out_byte  = cur.bytes[idx];
  assign out_bad   = cur.bad[idx];
  assign out_last  = cur.last && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (busy && out_ready && !fin) begin
      idx <= idx + 2'd1;
    end else if (adv) begin
      busy <= !q_stat.empty;
      idx  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_job;
    end
  end

endmodule

>>> hdl/base64_codec_core.sv
// ----------------------------------------------------------------------------
// base64_codec_core: streaming base64 encoder and decoder
// each job goes into a queue slot and then into the result register cur before it is shown
// throughput: one item per cycle in, one result per cycle out while m_axis_tready is high
// encode averages four results per three items, so the result port slows the input
// a two-job queue parts intake from output; reset clears the queue, the group
// and selects encode
// ----------------------------------------------------------------------------
module base64_codec_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // bad_char
);
  import b64_pkg::*;

  q_stat_t q_stat;
  job_t    push_job, pop_job;
  logic    push, pop;

  b64_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_byte     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .in_ready    (s_axis_tready),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job)
  );

  b64_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_job   (pop_job),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_bad   (m_axis_tuser)
  );

endmodule
